/* src/rde_pkg.sv */
// shared constants, types and helpers for the raster draw engine
package rde_pkg;

  // field widths
  localparam int FUNC_W      = 3;
  localparam int XA_W        = 6;
  localparam int XB_W        = 7;
  localparam int COLOR_W     = 8;
  localparam int CODE_W      = 3;
  // walker coordinates reach xa + xb - 1 = 189 for a rectangle
  localparam int COORD_W     = 8;
  localparam int ERR_W       = 10;
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 8;

  // default frame geometry
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  // reset value of the frame size registers
  localparam logic [CFG_W-1:0] FRAME_SIZE_RST = 7'd64;

  // command codes
  localparam logic [FUNC_W-1:0] FUNC_HSPAN   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_VSPAN   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_OUTLINE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_FILL    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_LINE    = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd5;

  // colour codes
  localparam logic [CODE_W-1:0] CODE_OTHER = 3'd0;
  localparam logic [CODE_W-1:0] CODE_RED   = 3'd1;
  localparam logic [CODE_W-1:0] CODE_GREEN = 3'd2;
  localparam logic [CODE_W-1:0] CODE_BLUE  = 3'd3;
  localparam logic [CODE_W-1:0] CODE_WHITE = 3'd4;
  localparam logic [CODE_W-1:0] CODE_BLACK = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [COLOR_W-1:0] COMP_FULL = 8'd255;
  localparam logic [COLOR_W-1:0] COMP_NONE = 8'd0;

  // controller to datapath commands
  typedef struct packed {
    logic clr;
    logic load;
    logic step;
    logic rd;
    logic emit;
  } rde_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic last;
    logic empty;
  } rde_sts_t;

  // map an exact rgb triple to a colour code
  function automatic logic [CODE_W-1:0] colour_code(input logic [COLOR_W-1:0] r,
                                                   input logic [COLOR_W-1:0] g,
                                                   input logic [COLOR_W-1:0] b);
    logic [CODE_W-1:0] code;
    code = CODE_OTHER;
    if (r == COMP_FULL && g == COMP_NONE && b == COMP_NONE) code = CODE_RED;
    else if (r == COMP_NONE && g == COMP_FULL && b == COMP_NONE) code = CODE_GREEN;
    else if (r == COMP_NONE && g == COMP_NONE && b == COMP_FULL) code = CODE_BLUE;
    else if (r == COMP_FULL && g == COMP_FULL && b == COMP_FULL) code = CODE_WHITE;
    else if (r == COMP_NONE && g == COMP_NONE && b == COMP_NONE) code = CODE_BLACK;
    return code;
  endfunction

endpackage

/* src/rde_ctrl.sv */
// controller state machine sequencing clear, draw, read and result transfer
module rde_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [rde_pkg::FUNC_W-1:0] in_func,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output rde_pkg::rde_cmd_t        cmd,
  input  rde_pkg::rde_sts_t        sts
);
  import rde_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_READ,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // next state and commands
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          case (in_func) inside
            FUNC_HSPAN, FUNC_VSPAN, FUNC_OUTLINE, FUNC_FILL, FUNC_LINE: state_nxt = S_RUN;
            FUNC_READ: state_nxt = S_READ;
            default:   state_nxt = S_FIN;
          endcase
        end
      end
      S_RUN: begin
        if (sts.empty) begin
          state_nxt = S_FIN;
        end else begin
          cmd.step = 1'b1;
          if (sts.last) state_nxt = S_FIN;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/rde_datapath.sv */
// datapath: frame memory, pixel walker for rectangles and lines, config and result registers
module rde_datapath #(
  parameter int MAX_WIDTH  = rde_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rde_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rde_pkg::rde_cmd_t             cmd,
  output rde_pkg::rde_sts_t             sts,
  input  logic [rde_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                          cfg_wr,
  input  logic [rde_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rde_pkg::CFG_W-1:0]     cfg_data,
  output logic [rde_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import rde_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // input field unpack
  logic [FUNC_W-1:0]  f_func;
  logic [XA_W-1:0]    f_xa, f_ya;
  logic [XB_W-1:0]    f_xb, f_yb;
  logic [COLOR_W-1:0] f_red, f_green, f_blue;

  assign f_func  = in_tdata[2:0];
  assign f_xa    = in_tdata[8:3];
  assign f_ya    = in_tdata[14:9];
  assign f_xb    = in_tdata[21:15];
  assign f_yb    = in_tdata[28:22];
  assign f_red   = in_tdata[36:29];
  assign f_green = in_tdata[44:37];
  assign f_blue  = in_tdata[52:45];

  // registers
  logic [CFG_W-1:0]        fw_r, fh_r;
  logic [AW-1:0]           clr_cnt_r;
  logic                    clip_r;
  logic [FUNC_W-1:0]       func_r;
  logic [CODE_W-1:0]       code_r;
  logic [COORD_W-1:0]      x_r, y_r, xs_r, xl_r, ys_r, yl_r;
  logic                    empty_r, line_r, outline_r, xmaj_r, sx_neg_r, sy_neg_r;
  logic signed [ERR_W-1:0] e_r, dmaj_r, dmaj2_r, dmin2_r;
  logic [CODE_W-1:0]       rd_data_r;
  logic [CODE_W-1:0]       pix_out_r;
  logic                    clip_out_r;
  logic [CODE_W-1:0]       mem [DEPTH];

  // setup values computed from the incoming command
  logic [COORD_W-1:0] xa_ext, ya_ext, xb_ext, yb_ext, adx, ady;
  logic [COORD_W-1:0] s_xs, s_xl, s_ys, s_yl;
  logic               s_empty;

  assign xa_ext = COORD_W'(f_xa);
  assign ya_ext = COORD_W'(f_ya);
  assign xb_ext = COORD_W'(f_xb);
  assign yb_ext = COORD_W'(f_yb);
  assign adx = (xb_ext >= xa_ext) ? (xb_ext - xa_ext) : (xa_ext - xb_ext);
  assign ady = (yb_ext >= ya_ext) ? (yb_ext - ya_ext) : (ya_ext - yb_ext);

  // per command walk bounds
  always_comb begin
    s_xs    = xa_ext;
    s_ys    = ya_ext;
    s_xl    = xa_ext;
    s_yl    = ya_ext;
    s_empty = 1'b1;
    case (f_func)
      FUNC_HSPAN: begin
        s_xl    = xb_ext - COORD_W'(1);
        s_empty = (xb_ext <= xa_ext);
      end
      FUNC_VSPAN: begin
        s_yl    = yb_ext - COORD_W'(1);
        s_empty = (yb_ext <= ya_ext);
      end
      FUNC_OUTLINE, FUNC_FILL: begin
        s_xl    = xa_ext + xb_ext - COORD_W'(1);
        s_yl    = ya_ext + yb_ext - COORD_W'(1);
        s_empty = (f_xb == '0) || (f_yb == '0);
      end
      FUNC_LINE: begin
        s_xl    = xb_ext;
        s_yl    = yb_ext;
        s_empty = 1'b0;
      end
      default: s_empty = 1'b1;
    endcase
  end

  // current pixel: frame test and memory address
  logic          pix_inside;
  logic [31:0]   pix_addr_full;
  logic [AW-1:0] pix_addr;

  assign pix_inside = (x_r < COORD_W'(fw_r)) && (y_r < COORD_W'(fh_r)) &&
                      (32'(x_r) < 32'(MAX_WIDTH)) && (32'(y_r) < 32'(MAX_HEIGHT));
  assign pix_addr_full = 32'(y_r) * 32'(MAX_WIDTH) + 32'(x_r);
  assign pix_addr      = pix_addr_full[AW-1:0];

  // bresenham step
  logic signed [ERR_W-1:0] e_acc, e_step;
  logic                    minor_step;
  logic [COORD_W-1:0]      x_inc, y_inc;

  assign e_acc      = e_r + dmin2_r;
  assign minor_step = (e_acc >= dmaj_r);
  assign e_step     = minor_step ? (e_acc - dmaj2_r) : e_acc;
  assign x_inc      = sx_neg_r ? (x_r - COORD_W'(1)) : (x_r + COORD_W'(1));
  assign y_inc      = sy_neg_r ? (y_r - COORD_W'(1)) : (y_r + COORD_W'(1));

  // next pixel position
  logic [COORD_W-1:0] x_nxt, y_nxt;
  logic               last_line, last_rect;

  assign last_line = xmaj_r ? (x_r == xl_r) : (y_r == yl_r);
  assign last_rect = (x_r == xl_r) && (y_r == yl_r);

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (line_r) begin
      if (xmaj_r) begin
        x_nxt = x_inc;
        if (minor_step) y_nxt = y_inc;
      end else begin
        y_nxt = y_inc;
        if (minor_step) x_nxt = x_inc;
      end
    end else if (x_r == xl_r) begin
      x_nxt = xs_r;
      y_nxt = y_r + COORD_W'(1);
    end else if (outline_r && x_r == xs_r && y_r != ys_r && y_r != yl_r) begin
      // interior row of an outline: jump to the right edge
      x_nxt = xl_r;
    end else begin
      x_nxt = x_r + COORD_W'(1);
    end
  end

  assign sts.last     = line_r ? last_line : last_rect;
  assign sts.empty    = empty_r;
  assign sts.clr_last = (clr_cnt_r == AW'(DEPTH - 1));

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r      <= FRAME_SIZE_RST;
      fh_r      <= FRAME_SIZE_RST;
      clr_cnt_r <= '0;
      clip_r    <= 1'b0;
    end else begin
      if (cfg_wr && cfg_index == REG_FRAME_WIDTH)  fw_r <= cfg_data;
      if (cfg_wr && cfg_index == REG_FRAME_HEIGHT) fh_r <= cfg_data;
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.load) clip_r <= 1'b0;
      else if ((cmd.step || cmd.rd) && !pix_inside) clip_r <= 1'b1;
    end
  end

  // walker payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r    <= f_func;
      code_r    <= colour_code(f_red, f_green, f_blue);
      x_r       <= xa_ext;
      y_r       <= ya_ext;
      xs_r      <= s_xs;
      xl_r      <= s_xl;
      ys_r      <= s_ys;
      yl_r      <= s_yl;
      empty_r   <= s_empty;
      line_r    <= (f_func == FUNC_LINE);
      outline_r <= (f_func == FUNC_OUTLINE);
      xmaj_r    <= (adx >= ady);
      sx_neg_r  <= (xb_ext < xa_ext);
      sy_neg_r  <= (yb_ext < ya_ext);
      e_r       <= '0;
      dmaj_r    <= (adx >= ady) ? ERR_W'(adx) : ERR_W'(ady);
      dmaj2_r   <= (adx >= ady) ? ERR_W'({adx, 1'b0}) : ERR_W'({ady, 1'b0});
      dmin2_r   <= (adx >= ady) ? ERR_W'({ady, 1'b0}) : ERR_W'({adx, 1'b0});
    end else if (cmd.step) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      if (line_r) e_r <= e_step;
    end
  end

  // frame memory: one write port, one registered read
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [CODE_W-1:0]   wr_data;

  assign wr_en   = cmd.clr || (cmd.step && pix_inside);
  assign wr_addr = cmd.clr ? clr_cnt_r : pix_addr;
  assign wr_data = cmd.clr ? CODE_OTHER : code_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd) rd_data_r <= pix_inside ? mem[pix_addr] : CODE_OTHER;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pix_out_r  <= (func_r == FUNC_READ) ? rd_data_r : CODE_OTHER;
      clip_out_r <= clip_r;
    end
  end

  assign out_tdata = {4'b0000, clip_out_r, pix_out_r};

endmodule

/* src/raster_draw_engine_core.sv */
// Raster draw engine: 3-bit colour framebuffer with span, rectangle, line and read commands.
// Sequence: a draw steps through its pixels in S_RUN, a read passes S_READ, an empty draw
// ends S_RUN at once and an unused code goes straight to S_FIN, which waits on out_tready.
// Commands are taken one at a time: in_tready stays low until the result is emitted.
// Reset: synchronous active-low; afterwards a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT
// frame entries (4096 by default) while in_tready stays low; config writes are taken.
module raster_draw_engine_core #(
  parameter int MAX_WIDTH  = rde_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rde_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // func[2:0], xa[8:3], ya[14:9], xb[21:15], yb[28:22], red[36:29], green[44:37],
  // blue[52:45], zero fill above
  input  logic [rde_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // pixel_code[2:0], clipped[3], zero fill above
  output logic [rde_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rde_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rde_pkg::CFG_W-1:0]       cfg_data
);
  import rde_pkg::*;

  rde_cmd_t cmd;
  rde_sts_t sts;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  rde_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tdata[FUNC_W-1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  rde_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata)
  );

  // one command in flight: no input transfer right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a command is still in work");

  // a nonzero pixel code only comes from an in-frame read
  a_code_not_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2:0] != CODE_OTHER) |-> !out_tdata[3])
    else $error("pixel code reported for a clipped command");

  // datapath commands are mutually exclusive
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr, cmd.load, cmd.step, cmd.rd, cmd.emit}))
    else $error("more than one datapath command in a cycle");

endmodule
